// ----- src/hcr_pkg.sv -----
`timescale 1ns / 1ps
package hcr_pkg;

  localparam int MaxStopsDef = 6;

  localparam int CfgIdxW = 3;
  localparam int CntW    = 3;
  localparam int StopW   = 40;
  localparam int PosW    = 8;
  localparam int ChanW   = 8;
  localparam int NumChan = 4;
  localparam int NumW    = 2 * ChanW;
  localparam int ColorW  = NumChan * ChanW;

  localparam int MinStops = 2;

  localparam logic [CfgIdxW-1:0] RegEnable   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCount    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegStopZero = CfgIdxW'(2);

  localparam logic [CntW-1:0]  CountReset   = CntW'(2);
  localparam logic [StopW-1:0] StopOneReset = {StopW{1'b1}};

  // Channel 3 is red, channel 0 is alpha, matching the stop packing.
  typedef logic [NumChan-1:0][ChanW-1:0] color_t;

  typedef struct packed {
    color_t          lo_color;
    color_t          hi_color;
    logic [PosW-1:0] span;
    logic [PosW-1:0] offset;
  } seg_t;

  typedef struct packed {
    logic [NumChan-1:0][NumW-1:0] rem;
    color_t                       quo;
    logic [PosW-1:0]              span;
  } div_t;

endpackage

// ----- src/hcr_if.sv -----
`timescale 1ns / 1ps
interface hcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface hcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

interface hcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [39:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/hcr_seg.sv -----
`timescale 1ns / 1ps
module hcr_seg
  import hcr_pkg::*;
#(
  parameter int MAX_STOPS = MaxStopsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             enable_i,
  input  logic [CntW-1:0]  count_i,
  input  logic [StopW-1:0] stops_i [MAX_STOPS],
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PosW-1:0]  height_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output seg_t             out_o
);

  logic [PosW-1:0] pos [MAX_STOPS];
  color_t          col [MAX_STOPS];
  logic [CntW-1:0] n_eff;
  logic [CntW-1:0] last_idx;
  logic [PosW-1:0] last_pos;
  color_t          last_col;
  logic            found;
  seg_t            seg_d;
  seg_t            seg_q;
  logic            valid_q;

  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      pos[i] = stops_i[i][StopW-1 -: PosW];
      col[i] = stops_i[i][ColorW-1:0];
    end
    if (count_i < CntW'(MinStops)) begin
      n_eff = CntW'(MinStops);
    end else if (count_i > CntW'(MAX_STOPS)) begin
      n_eff = CntW'(MAX_STOPS);
    end else begin
      n_eff = count_i;
    end
    last_idx = n_eff - CntW'(1);
    last_pos = '0;
    last_col = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (CntW'(i) == last_idx) begin
        last_pos = pos[i];
        last_col = col[i];
      end
    end
  end

  // A plain color is passed on as lo_color over a span of one, so the
  // interpolator returns it unchanged.
  always_comb begin
    found           = 1'b0;
    seg_d.lo_color  = '0;
    seg_d.hi_color  = '0;
    seg_d.span      = PosW'(1);
    seg_d.offset    = '0;
    if (!enable_i) begin
      seg_d.lo_color = '1;
    end else if (height_i <= pos[0]) begin
      seg_d.lo_color = col[0];
    end else if (height_i >= last_pos) begin
      seg_d.lo_color = last_col;
    end else begin
      for (int i = 0; i < MAX_STOPS - 1; i++) begin
        if (!found && (CntW'(i + 1) < n_eff) && (pos[i] <= height_i)
            && (height_i <= pos[i+1])) begin
          found = 1'b1;
          if (pos[i+1] == pos[i]) begin
            seg_d.lo_color = col[i+1];
          end else begin
            seg_d.lo_color = col[i];
            seg_d.hi_color = col[i+1];
            seg_d.span     = pos[i+1] - pos[i];
            seg_d.offset   = height_i - pos[i];
          end
        end
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      seg_q <= seg_d;
    end
  end

endmodule

// ----- src/hcr_mix.sv -----
`timescale 1ns / 1ps
module hcr_mix
  import hcr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  seg_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output div_t out_o
);

  logic [PosW-1:0] rest;
  logic [NumW-1:0] half;
  div_t            mix_d;
  div_t            mix_q;
  logic            valid_q;

  always_comb begin
    rest = in_i.span - in_i.offset;
    half = NumW'(in_i.span[PosW-1:1]);
    for (int c = 0; c < NumChan; c++) begin
      mix_d.rem[c] = NumW'(in_i.lo_color[c]) * NumW'(rest)
                   + NumW'(in_i.hi_color[c]) * NumW'(in_i.offset) + half;
    end
    mix_d.quo  = '0;
    mix_d.span = in_i.span;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mix_q <= mix_d;
    end
  end

endmodule

// ----- src/hcr_div_stage.sv -----
`timescale 1ns / 1ps
module hcr_div_stage
  import hcr_pkg::*;
#(
  parameter int STEP_HI = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  div_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output div_t out_o
);

  // Two restoring steps per stage; the quotient is known to fit in eight bits.
  div_t            div_d;
  div_t            div_q;
  logic [NumW-1:0] shifted;
  logic            valid_q;

  always_comb begin
    div_d   = in_i;
    shifted = '0;
    for (int j = 0; j < 2; j++) begin
      shifted = NumW'(in_i.span) << (STEP_HI - j);
      for (int c = 0; c < NumChan; c++) begin
        if (div_d.rem[c] >= shifted) begin
          div_d.rem[c]               = div_d.rem[c] - shifted;
          div_d.quo[c][STEP_HI - j]  = 1'b1;
        end
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      div_q <= div_d;
    end
  end

endmodule

// ----- src/height_color_ramp_unit.sv -----
`timescale 1ns / 1ps
// Maps an 8-bit height to an RGBA color through a ramp of up to MAX_STOPS stops.
// The unit takes one item per cycle while the output is not stalled: one
// stage picks the segment, one forms the weighted sums, and four stages run a
// restoring divider two quotient bits at a time for all four channels at once.
// Every stage holds its own valid bit, so empty stages fill while the output
// is stalled. Configuration writes are taken in every cycle and must only be
// issued while no item is in flight.
module height_color_ramp_unit
  import hcr_pkg::*;
#(
  parameter int MAX_STOPS = MaxStopsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  hcr_cfg_if.sink   cfg_i,
  hcr_in_if.sink    in_i,
  hcr_out_if.source out_o
);

  localparam int NumDiv = ChanW / 2;

  logic             enable_q;
  logic [CntW-1:0]  count_q;
  logic [StopW-1:0] stop_q [MAX_STOPS];
  logic             cfg_we;

  seg_t seg;
  logic seg_valid;
  logic seg_ready;
  div_t stage [NumDiv+1];
  logic stage_valid [NumDiv+1];
  logic stage_ready [NumDiv+1];

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      count_q  <= CountReset;
    end else if (cfg_we) begin
      if (cfg_i.index == RegEnable) begin
        enable_q <= cfg_i.data[0];
      end
      if (cfg_i.index == RegCount) begin
        count_q <= cfg_i.data[CntW-1:0];
      end
    end
  end

  for (genvar s = 0; s < MAX_STOPS; s++) begin : g_stop
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stop_q[s] <= (s == 1) ? StopOneReset : '0;
      end else if (cfg_we && (cfg_i.index == RegStopZero + CfgIdxW'(s))) begin
        stop_q[s] <= cfg_i.data;
      end
    end
  end

  hcr_seg #(
    .MAX_STOPS(MAX_STOPS)
  ) u_seg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enable_i   (enable_q),
    .count_i    (count_q),
    .stops_i    (stop_q),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .height_i   (in_i.height),
    .out_valid_o(seg_valid),
    .out_ready_i(seg_ready),
    .out_o      (seg)
  );

  hcr_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (seg_valid),
    .in_ready_o (seg_ready),
    .in_i       (seg),
    .out_valid_o(stage_valid[0]),
    .out_ready_i(stage_ready[0]),
    .out_o      (stage[0])
  );

  for (genvar k = 0; k < NumDiv; k++) begin : g_div
    hcr_div_stage #(
      .STEP_HI(ChanW - 1 - 2 * k)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (stage_valid[k]),
      .in_ready_o (stage_ready[k]),
      .in_i       (stage[k]),
      .out_valid_o(stage_valid[k+1]),
      .out_ready_i(stage_ready[k+1]),
      .out_o      (stage[k+1])
    );
  end

  assign stage_ready[NumDiv] = out_o.ready;
  assign out_o.valid         = stage_valid[NumDiv];
  assign out_o.red           = stage[NumDiv].quo[3];
  assign out_o.green         = stage[NumDiv].quo[2];
  assign out_o.blue          = stage[NumDiv].quo[1];
  assign out_o.alpha         = stage[NumDiv].quo[0];

endmodule
